/* sv/byte_budget_lru_tag_store_unit_macros.svh */
// ----------------------------------------------------------------------------
// Byte-budget LRU tag store assertion macros
// Shared assertion forms for the tag store RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_TAG_STORE_UNIT_MACROS_SVH
`define BYTE_BUDGET_LRU_TAG_STORE_UNIT_MACROS_SVH

// Condition a holds in the same cycle as b.
`define BBLTS_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tag store check failed");

// Condition a is followed by b in the next cycle.
`define BBLTS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tag store check failed");

`endif

/* sv/bblts_pkg.sv */
// ----------------------------------------------------------------------------
// Byte-budget LRU tag store package
// Types and constants shared by the slot cells and the top level.
// ----------------------------------------------------------------------------
package bblts_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 64;
    localparam int SIZE_W      = 24;
    localparam int HANDLE_W    = 32;
    localparam int CNT_W       = 32;
    localparam int EVC_W       = 5;
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVALIDATE = 2'd2;
    // Unused command code: reports the totals and changes nothing.
    localparam logic [CMD_W-1:0] CMD_RESERVED   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_ACT,
        S_EVICT,
        S_FULL,
        S_INSERT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TOUCH,
        OP_REMOVE,
        OP_EVICT,
        OP_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [KEY_W-1:0]      key;
        logic [SIZE_W-1:0]     size;
        logic [HANDLE_W-1:0]   handle;
    } t_cell_cmd;

endpackage

/* sv/bblts_cell.sv */
// ----------------------------------------------------------------------------
// Tag store slot cell
// One slot: valid bit, key, size, handle and recency rank. The free-slot
// claim token ripples from cell to cell.
// ----------------------------------------------------------------------------
module bblts_cell
    import bblts_pkg::*;
#(
    parameter int RANK_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  logic [RANK_W-1:0]   i_rank,
    input  logic                i_claim,
    output logic                o_claim,
    output logic                o_valid,
    output logic                o_sel,
    output logic [RANK_W-1:0]   o_sel_rank,
    output logic [SIZE_W-1:0]   o_sel_size,
    output logic [HANDLE_W-1:0] o_sel_handle
);

    logic                r_valid, n_valid;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [RANK_W-1:0]   r_rank, n_rank;
    logic                w_match;

    assign w_match = r_valid && (r_key == i_cmd.key);
    assign o_sel   = (i_cmd.op == OP_EVICT) ? (r_valid && (r_rank == i_rank)) : w_match;
    assign o_claim = i_claim || !r_valid;
    assign o_valid = r_valid;
    assign o_sel_rank   = o_sel ? r_rank   : '0;
    assign o_sel_size   = o_sel ? r_size   : '0;
    assign o_sel_handle = o_sel ? r_handle : '0;

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_size   = r_size;
        n_handle = r_handle;
        n_rank   = r_rank;
        unique case (i_cmd.op)
            OP_TOUCH: begin
                if (w_match) begin
                    n_rank = '0;
                end else if (r_valid && (r_rank < i_rank)) begin
                    n_rank = r_rank + RANK_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_match) begin
                    n_valid = 1'b0;
                end else if (r_valid && (r_rank > i_rank)) begin
                    n_rank = r_rank - RANK_W'(1);
                end
            end
            OP_EVICT: begin
                // The oldest entry holds the highest rank, so no other rank moves.
                if (o_sel) begin
                    n_valid = 1'b0;
                end
            end
            OP_INSERT: begin
                if (r_valid) begin
                    n_rank = r_rank + RANK_W'(1);
                end else if (!i_claim) begin
                    n_valid  = 1'b1;
                    n_key    = i_cmd.key;
                    n_size   = i_cmd.size;
                    n_handle = i_cmd.handle;
                    n_rank   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key    <= n_key;
        r_size   <= n_size;
        r_handle <= n_handle;
        r_rank   <= n_rank;
    end

endmodule

/* sv/byte_budget_lru_tag_store_unit.sv */
// ----------------------------------------------------------------------------
// Byte-budget LRU tag store
// Fully associative LRU metadata store with a byte budget on its contents.
// ----------------------------------------------------------------------------
// One item is handled at a time. A lookup or invalidate passes through the
// find, act and done states; an insert also passes through the evict, full and
// insert states, staying in evict while it removes entries. The eviction walk
// over the row of slot cells removes one least-recent entry per cycle. A finished
// result waits in the output register while the next item is taken.
module byte_budget_lru_tag_store_unit
    import bblts_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], key_tag[65:2], entry_bytes[89:66], payload_handle[121:90]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0], found_handle[32:1], evicted_count[37:33], hit_count[69:38],
    // miss_count[101:70], bytes_in_use[133:102]
    output logic [135:0] m_axis_tdata
);

    `include "byte_budget_lru_tag_store_unit_macros.svh"

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CW     = $clog2(ENTRIES + 1);

    t_state              r_state, n_state;
    logic [31:0]         r_budget;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [SIZE_W-1:0]   r_size;
    logic [HANDLE_W-1:0] r_handle;
    logic [CW-1:0]       r_count, n_count;
    logic [31:0]         r_used, n_used;
    logic [CNT_W-1:0]    r_hits, n_hits;
    logic [CNT_W-1:0]    r_misses, n_misses;
    logic [EVC_W-1:0]    r_evicted, n_evicted;
    logic                r_hit, n_hit;
    logic                r_found_any;
    logic [RANK_W-1:0]   r_found_rank;
    logic [HANDLE_W-1:0] r_found_handle;
    logic [SIZE_W-1:0]   r_found_size;
    logic                r_out_valid;
    logic [135:0]        r_out;

    t_cell_cmd           w_cmd;
    logic [RANK_W-1:0]   w_rank;
    logic [RANK_W-1:0]   w_oldest;
    logic [ENTRIES:0]    w_claim;
    logic [ENTRIES-1:0]  w_valid;
    logic [ENTRIES-1:0]  w_sel;
    logic [RANK_W-1:0]   w_sel_rank   [ENTRIES];
    logic [SIZE_W-1:0]   w_sel_size   [ENTRIES];
    logic [HANDLE_W-1:0] w_sel_handle [ENTRIES];
    logic [RANK_W-1:0]   w_or_rank;
    logic [SIZE_W-1:0]   w_or_size;
    logic [HANDLE_W-1:0] w_or_handle;
    logic                w_over;
    logic                w_in_xfer;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign w_oldest      = RANK_W'(r_count - CW'(1));
    assign w_over        = ({1'b0, r_used} + {9'b0, r_size}) > {1'b0, r_budget};
    assign w_claim[0]    = 1'b0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            bblts_cell #(.RANK_W(RANK_W)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_rank       (w_rank),
                .i_claim      (w_claim[g]),
                .o_claim      (w_claim[g+1]),
                .o_valid      (w_valid[g]),
                .o_sel        (w_sel[g]),
                .o_sel_rank   (w_sel_rank[g]),
                .o_sel_size   (w_sel_size[g]),
                .o_sel_handle (w_sel_handle[g])
            );
        end
    endgenerate

    // At most one cell is selected, so an OR gathers its fields.
    always_comb begin
        w_or_rank   = '0;
        w_or_size   = '0;
        w_or_handle = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_or_rank   = w_or_rank   | w_sel_rank[i];
            w_or_size   = w_or_size   | w_sel_size[i];
            w_or_handle = w_or_handle | w_sel_handle[i];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_used     = r_used;
        n_hits     = r_hits;
        n_misses   = r_misses;
        n_evicted  = r_evicted;
        n_hit      = r_hit;
        w_cmd.op     = OP_NOP;
        w_cmd.key    = r_key;
        w_cmd.size   = r_size;
        w_cmd.handle = r_handle;
        w_rank     = r_found_rank;
        unique case (r_state)
            S_IDLE: begin
                n_evicted = '0;
                n_hit     = 1'b0;
                if (w_in_xfer) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                n_state = S_DONE;
                if (r_cmd == CMD_LOOKUP) begin
                    if (r_found_any) begin
                        w_cmd.op = OP_TOUCH;
                        n_hit    = 1'b1;
                        if (r_hits != '1) begin
                            n_hits = r_hits + CNT_W'(1);
                        end
                    end else if (r_misses != '1) begin
                        n_misses = r_misses + CNT_W'(1);
                    end
                end else if ((r_cmd == CMD_INSERT) || (r_cmd == CMD_INVALIDATE)) begin
                    if (r_found_any) begin
                        w_cmd.op = OP_REMOVE;
                        n_used   = r_used - {8'b0, r_found_size};
                        n_count  = r_count - CW'(1);
                    end
                    if (r_cmd == CMD_INSERT) begin
                        n_state = S_EVICT;
                    end
                end
            end
            S_EVICT: begin
                w_rank = w_oldest;
                if (w_over && (r_count != '0)) begin
                    w_cmd.op  = OP_EVICT;
                    n_used    = r_used - {8'b0, w_or_size};
                    n_count   = r_count - CW'(1);
                    if (r_evicted != '1) begin
                        n_evicted = r_evicted + EVC_W'(1);
                    end
                end else begin
                    n_state = S_FULL;
                end
            end
            S_FULL: begin
                w_rank  = w_oldest;
                n_state = S_INSERT;
                if (r_count == CW'(ENTRIES)) begin
                    w_cmd.op  = OP_EVICT;
                    n_used    = r_used - {8'b0, w_or_size};
                    n_count   = r_count - CW'(1);
                    if (r_evicted != '1) begin
                        n_evicted = r_evicted + EVC_W'(1);
                    end
                end
            end
            S_INSERT: begin
                w_cmd.op = OP_INSERT;
                n_used   = r_used + {8'b0, r_size};
                n_count  = r_count + CW'(1);
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_budget    <= '0;
            r_count     <= '0;
            r_used      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicted   <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_used    <= n_used;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
            r_evicted <= n_evicted;
            r_hit     <= n_hit;
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end
            if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd    <= s_axis_tdata[1:0];
            r_key    <= s_axis_tdata[65:2];
            r_size   <= s_axis_tdata[89:66];
            r_handle <= s_axis_tdata[121:90];
        end
        if (r_state == S_FIND) begin
            r_found_any    <= |w_sel;
            r_found_rank   <= w_or_rank;
            r_found_handle <= w_or_handle;
            r_found_size   <= w_or_size;
        end
        if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out <= {2'b0, r_used, r_misses, r_hits, r_evicted,
                      (r_hit ? r_found_handle : {HANDLE_W{1'b0}}), r_hit};
        end
    end

    `BBLTS_ASSERT_SAME(a_count_tracks_valid, i_clk, i_rst_n, 1'b1, $countones(w_valid) == r_count)
    `BBLTS_ASSERT_SAME(a_insert_has_room, i_clk, i_rst_n, r_state == S_INSERT, r_count < CW'(ENTRIES))
    `BBLTS_ASSERT_NEXT(a_accept_starts_search, i_clk, i_rst_n, w_in_xfer, r_state == S_FIND)
    `BBLTS_ASSERT_SAME(a_single_match, i_clk, i_rst_n, r_state == S_FIND, $onehot0(w_sel))

endmodule
